[rtl/pcq_pkg.sv]
// Package for the per-channel signed 4-bit weight quantizer.
// Holds command codes, float32 constants and the unpack and round-and-pack helpers.
// No dependencies.
package pcq_pkg;

  localparam int CmdW = 2;
  localparam logic [CmdW-1:0] CMD_SCAN   = 2'd0;
  localparam logic [CmdW-1:0] CMD_FINISH = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUANT  = 2'd2;

  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP_SEVEN = 32'h40E0_0000;
  localparam logic [31:0] FP_INF   = 32'h7F80_0000;
  localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;

  // Significand and unbiased exponent of the float32 value of 1/15.
  localparam logic [23:0]        INV15_MANT = 24'h88_8889;
  localparam logic signed [10:0] INV15_EXP  = -11'sd4;

  // Quotient bits produced by the divider, one per cycle.
  localparam int DivSteps = 28;

  typedef struct packed {
    logic               sign;
    logic signed [10:0] exp;
    logic [23:0]        mant;
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_unp_t;

  // Splits a float32 into sign, exponent and a significand with its top bit set.
  // Subnormal inputs are normalised here, so value = mant * 2^(exp - 23).
  function automatic fp_unp_t fp_unpack(logic [31:0] b);
    fp_unp_t    u;
    logic [23:0] m;
    logic [4:0]  lz;
    u.sign = b[31];
    u.zero = (b[30:0] == 31'd0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    m  = {1'b0, b[22:0]};
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    if (b[30:23] != 8'd0) begin
      u.mant = {1'b1, b[22:0]};
      u.exp  = $signed({3'b000, b[30:23]}) - 11'sd127;
    end else begin
      u.mant = m << lz;
      u.exp  = -11'sd126 - $signed({6'b0, lz});
    end
    return u;
  endfunction

  // Rounds sig * 2^(exp - 26) to float32, nearest even; sig has its top bit set.
  // Handles overflow to infinity and gradual underflow.
  function automatic logic [31:0] fp_pack(logic s, logic signed [10:0] exp,
                                          logic [26:0] sig, logic st);
    logic signed [10:0] be;
    logic signed [10:0] nsh;
    logic [4:0]         sh;
    logic [26:0]        mask;
    logic [26:0]        s2;
    logic               lost;
    logic               up;
    logic [7:0]         be8;
    logic [30:0]        body;
    logic [31:0]        res;
    be   = exp + 11'sd127;
    nsh  = 11'sd1 - be;
    sh   = 5'd0;
    mask = 27'd0;
    if (be <= 11'sd0) begin
      sh   = (nsh > 11'sd27) ? 5'd27 : nsh[4:0];
      mask = ~(27'h7FF_FFFF << sh);
      lost = |(sig & mask);
      s2   = sig >> sh;
      be8  = 8'd0;
    end else begin
      lost = 1'b0;
      s2   = sig;
      be8  = be[7:0];
    end
    up   = s2[2] & (s2[1] | s2[0] | st | lost | s2[3]);
    body = {be8, s2[25:3]} + {30'd0, up};
    if (be >= 11'sd255) res = {s, FP_INF[30:0]};
    else res = {s, body};
    return res;
  endfunction

endpackage

[rtl/pcq_in_if.sv]
// Input channel of the quantizer: command and float32 value with valid/ready.
// Depends on pcq_pkg.
interface pcq_in_if;
  import pcq_pkg::*;
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [31:0]     value_bits;
  modport source (output valid, command, value_bits, input ready);
  modport sink   (input valid, command, value_bits, output ready);
endinterface

[rtl/pcq_out_if.sv]
// Result channel of the quantizer: weight, or scale and bias, with valid/ready.
// No dependencies.
interface pcq_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [3:0]  weight_q;
  logic [31:0]        scale_bits;
  logic signed [31:0] bias_q;
  logic               out_of_range;
  modport source (output valid, kind, weight_q, scale_bits, bias_q, out_of_range,
                  input ready);
  modport sink   (input valid, kind, weight_q, scale_bits, bias_q, out_of_range,
                  output ready);
endinterface

[rtl/per_channel_s4_weight_quantizer.sv]
// Per-channel symmetric int4 weight quantizer, top level.
// Depends on pcq_pkg, pcq_in_if and pcq_out_if.
//
// Usage: a channel is sent twice. First every weight goes in as a scan command,
// which folds its magnitude into a running maximum. A finish command carrying the
// bias then fixes scale = max / 7 and returns one transfer with the scale and the
// bias quantized by scale / 15 (saturated to int32). Then every weight goes in
// again as a quantize command and comes back as a 4-bit value clamped to -8..7.
// Non-finite quotients return 0 with out_of_range set.
//
// Sequence: a scan transfer is folded in when taken and leaves the sequencer idle.
// A quantize runs one float division on a shared restoring divider that yields
// one quotient bit a cycle (28 steps), then rounds and registers its result. A
// finish runs a division, one multiply and a second division through the same
// divider before its result is registered.
// The input is ready only while the sequencer is idle, so it is ready again in
// the cycle the result is registered.
// The result register holds a finished transfer while the receiver stalls; a new
// item is taken meanwhile, and its result waits until the register is free.
// Reset (synchronous) clears the maximum, sets the scale to 1.0 and empties the
// result register.
module per_channel_s4_weight_quantizer (
  input logic        clk,
  input logic        rst,
  pcq_in_if.sink     items,
  pcq_out_if.source  results
);
  import pcq_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSET  = 4'd1;
  localparam logic [3:0] S_DITER = 4'd2;
  localparam logic [3:0] S_DRND  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_MRND  = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;

  localparam logic [1:0] P_SCALE = 2'd0;
  localparam logic [1:0] P_BIAS  = 2'd1;
  localparam logic [1:0] P_QUANT = 2'd2;

  logic [3:0]         state;
  logic [1:0]         phase;
  logic [30:0]        max_abs;
  logic [31:0]        scale_reg;
  logic [31:0]        bias_reg;
  logic [31:0]        a_bits;
  logic [31:0]        b_bits;
  logic               d_sign;
  logic signed [10:0] d_exp;
  logic [23:0]        d_mb;
  logic [24:0]        d_rem;
  logic [DivSteps-1:0] d_q;
  logic [4:0]         count;
  logic               d_spec;
  logic [31:0]        d_spec_bits;
  logic [31:0]        res_bits;
  logic [47:0]        prod;
  logic               m_sign;
  logic signed [10:0] m_exp;
  logic               m_spec;
  logic [31:0]        m_spec_bits;

  logic               out_valid;
  logic               out_kind;
  logic signed [3:0]  out_wq;
  logic [31:0]        out_scale;
  logic signed [31:0] out_bias;
  logic               out_flag;

  logic    accept;
  fp_unp_t ua;
  fp_unp_t ub;
  fp_unp_t us;

  assign items.ready          = (state == S_IDLE);
  assign accept               = items.valid && items.ready;
  assign results.valid        = out_valid;
  assign results.kind         = out_kind;
  assign results.weight_q     = out_wq;
  assign results.scale_bits   = out_scale;
  assign results.bias_q       = out_bias;
  assign results.out_of_range = out_flag;

  // Operand unpacking for the divider set-up and for the scale multiply.
  assign ua = fp_unpack(a_bits);
  assign ub = fp_unpack(b_bits);
  assign us = fp_unpack(scale_reg);

  // One divider step: compare, subtract and shift the partial remainder.
  logic        step_ge;
  logic [24:0] step_rem;
  assign step_ge  = (d_rem >= {1'b0, d_mb});
  assign step_rem = step_ge ? (d_rem - {1'b0, d_mb}) : d_rem;

  // Normalisation and rounding of the quotient and of the product.
  logic [31:0] div_res;
  logic [31:0] mul_res;
  always_comb begin
    if (d_spec) div_res = d_spec_bits;
    else if (d_q[DivSteps-1]) div_res = fp_pack(d_sign, d_exp, d_q[DivSteps-1:1],
                                                d_q[0] | (d_rem != 25'd0));
    else div_res = fp_pack(d_sign, d_exp - 11'sd1, d_q[DivSteps-2:0], d_rem != 25'd0);
    if (m_spec) mul_res = m_spec_bits;
    else if (prod[47]) mul_res = fp_pack(m_sign, m_exp + 11'sd1, prod[47:21],
                                         |prod[20:0]);
    else mul_res = fp_pack(m_sign, m_exp, prod[46:20], |prod[19:0]);
  end

  // Conversion of the quotient to an integer, nearest even, with clamping.
  logic               cv_nonfinite;
  logic               cv_big;
  logic signed [10:0] cv_e;
  logic signed [10:0] cv_sh;
  logic [63:0]        cv_fix;
  logic [31:0]        cv_mag;
  logic               cv_up;
  logic signed [31:0] cv_bias;
  logic               cv_bias_flag;
  logic signed [3:0]  cv_wq;
  always_comb begin
    cv_nonfinite = (res_bits[30:23] == 8'hFF);
    cv_e         = $signed({3'b000, res_bits[30:23]}) - 11'sd127;
    cv_big       = (cv_e >= 11'sd31);
    cv_sh        = cv_e + 11'sd9;
    cv_fix       = 64'd0;
    if ((res_bits[30:23] != 8'd0) && (cv_sh >= 11'sd0) && !cv_big)
      cv_fix = {40'd0, 1'b1, res_bits[22:0]} << cv_sh[5:0];
    cv_up  = cv_fix[31] & ((|cv_fix[30:0]) | cv_fix[32]);
    cv_mag = cv_fix[63:32] + {31'd0, cv_up};

    cv_bias_flag = 1'b0;
    if (cv_nonfinite) begin
      cv_bias      = 32'sd0;
      cv_bias_flag = 1'b1;
    end else if (cv_big) begin
      if (res_bits == 32'hCF00_0000) begin
        cv_bias = 32'sh8000_0000;
      end else begin
        cv_bias      = res_bits[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        cv_bias_flag = 1'b1;
      end
    end else begin
      cv_bias = res_bits[31] ? -$signed(cv_mag) : $signed(cv_mag);
    end

    if (cv_nonfinite) cv_wq = 4'sd0;
    else if (cv_big) cv_wq = res_bits[31] ? -4'sd8 : 4'sd7;
    else if (res_bits[31]) cv_wq = (cv_mag >= 32'd8) ? -4'sd8 : -$signed(cv_mag[3:0]);
    else cv_wq = (cv_mag >= 32'd7) ? 4'sd7 : $signed(cv_mag[3:0]);
  end

  // Sequencer, datapath registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_QUANT;
      max_abs   <= 31'd0;
      scale_reg <= FP_ONE;
      out_valid <= 1'b0;
      count     <= 5'd0;
    end else begin
      // A taken result empties the register unless a new one is loaded this cycle.
      if (out_valid && results.ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (items.command)
              CMD_SCAN: begin
                if ((items.value_bits[30:0] <= FP_INF[30:0]) &&
                    (items.value_bits[30:0] > max_abs))
                  max_abs <= items.value_bits[30:0];
              end
              CMD_FINISH: begin
                a_bits   <= (max_abs == 31'd0) ? FP_ONE : {1'b0, max_abs};
                b_bits   <= FP_SEVEN;
                bias_reg <= items.value_bits;
                max_abs  <= 31'd0;
                phase    <= P_SCALE;
                state    <= S_DSET;
              end
              CMD_QUANT: begin
                a_bits <= items.value_bits;
                b_bits <= scale_reg;
                phase  <= P_QUANT;
                state  <= S_DSET;
              end
              default: begin
              end
            endcase
          end
        end
        S_DSET: begin
          d_sign <= ua.sign ^ ub.sign;
          d_exp  <= ua.exp - ub.exp;
          d_mb   <= ub.mant;
          d_rem  <= {1'b0, ua.mant};
          d_q    <= '0;
          count  <= 5'd0;
          d_spec <= ua.nan | ub.nan | (ua.inf & ub.inf) | (ua.zero & ub.zero) |
                    ua.inf | ub.zero | ua.zero | ub.inf;
          if (ua.nan | ub.nan | (ua.inf & ub.inf) | (ua.zero & ub.zero))
            d_spec_bits <= FP_QNAN;
          else if (ua.inf | ub.zero)
            d_spec_bits <= {ua.sign ^ ub.sign, FP_INF[30:0]};
          else
            d_spec_bits <= {ua.sign ^ ub.sign, 31'd0};
          state <= S_DITER;
        end
        S_DITER: begin
          d_rem <= {step_rem[23:0], 1'b0};
          d_q   <= {d_q[DivSteps-2:0], step_ge};
          count <= count + 5'd1;
          if (count == 5'(DivSteps - 1)) state <= S_DRND;
        end
        S_DRND: begin
          if (phase == P_SCALE) begin
            scale_reg <= div_res;
            state     <= S_MUL;
          end else begin
            res_bits <= div_res;
            state    <= S_OUT;
          end
        end
        S_MUL: begin
          prod        <= us.mant * INV15_MANT;
          m_sign      <= us.sign;
          m_exp       <= us.exp + INV15_EXP;
          m_spec      <= us.zero | us.inf | us.nan;
          m_spec_bits <= us.nan ? FP_QNAN :
                         (us.inf ? {us.sign, FP_INF[30:0]} : {us.sign, 31'd0});
          state       <= S_MRND;
        end
        S_MRND: begin
          a_bits <= bias_reg;
          b_bits <= mul_res;
          phase  <= P_BIAS;
          state  <= S_DSET;
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_flag  <= (phase == P_BIAS) ? cv_bias_flag : cv_nonfinite;
            if (phase == P_BIAS) begin
              out_kind  <= 1'b1;
              out_wq    <= 4'sd0;
              out_scale <= scale_reg;
              out_bias  <= cv_bias;
            end else begin
              out_kind  <= 1'b0;
              out_wq    <= cv_wq;
              out_scale <= 32'd0;
              out_bias  <= 32'sd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The input is only taken while the sequencer is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> (state == S_IDLE))
    else $error("input ready outside idle");

  // The divider never runs past its last quotient bit.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DITER) |-> (count <= 5'(DivSteps - 1)))
    else $error("divider step count out of range");

  // A finish transfer clears the running maximum.
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (items.command == CMD_FINISH)) |=> (max_abs == 31'd0))
    else $error("maximum not cleared by finish");

  // Weight results carry zero in the scale and bias fields.
  a_weight_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_kind) |-> ((out_scale == 32'd0) && (out_bias == 32'sd0)))
    else $error("weight result with scale or bias set");

  // A pending result is not overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready && (state == S_OUT)) |=> (state == S_OUT))
    else $error("result register overwritten while stalled");

endmodule
